@@ hdl/depth_to_jet_colour_macros.svh @@
// assertion macros shared by the depth to jet colour block
`ifndef DEPTH_TO_JET_COLOUR_MACROS_SVH
`define DEPTH_TO_JET_COLOUR_MACROS_SVH

// same-cycle implication, checked outside reset
`define DTJ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DTJ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/dtj_pkg.sv @@
// shared types and codes for the depth to jet colour block
package dtj_pkg;

    // what the back end has to do with one colour item
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_LOW,
        KIND_HIGH,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic  last;
    } item_ctl_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } back_state_t;

    localparam logic FUNC_SCAN   = 1'b0;
    localparam logic FUNC_COLOUR = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

endpackage

@@ hdl/dtj_front.sv @@
// front end: input handshake, range scan and colour item classification
module dtj_front #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic signed [DEPTH_BITS-1:0]    s_depth,
    input  logic                            s_last,
    input  logic                            q_full,
    output logic                            q_push,
    output dtj_pkg::item_ctl_t              q_ctl,
    output logic [DEPTH_BITS-2:0]           q_diff,
    output logic [DEPTH_BITS-2:0]           q_range
);

    localparam int VB = DEPTH_BITS - 1;

    logic [VB-1:0] run_min_reg, run_min_next;
    logic [VB-1:0] run_max_reg, run_max_next;
    logic [VB-1:0] frame_min_reg, frame_min_next;
    logic [VB-1:0] frame_range_reg, frame_range_next;

    logic                         accept;
    logic                         depth_pos;
    logic [VB-1:0]                dval;
    logic [VB-1:0]                min_upd;
    logic [VB-1:0]                max_upd;
    logic signed [DEPTH_BITS-1:0] diff;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign depth_pos = !s_depth[DEPTH_BITS-1] && (s_depth != '0);
    assign dval      = s_depth[VB-1:0];

    assign min_upd = (depth_pos && (dval < run_min_reg)) ? dval : run_min_reg;
    assign max_upd = (depth_pos && (dval > run_max_reg)) ? dval : run_max_reg;

    always_comb begin
        run_min_next     = run_min_reg;
        run_max_next     = run_max_reg;
        frame_min_next   = frame_min_reg;
        frame_range_next = frame_range_reg;
        if (accept && (s_func == dtj_pkg::FUNC_SCAN)) begin
            run_min_next = min_upd;
            run_max_next = max_upd;
            if (s_last) begin
                // latch the frame and restart the accumulators
                frame_min_next   = min_upd;
                frame_range_next = (max_upd >= min_upd) ? (max_upd - min_upd) : '0;
                run_min_next     = '1;
                run_max_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_min_reg     <= '1;
            run_max_reg     <= '0;
            frame_min_reg   <= '0;
            frame_range_reg <= '0;
        end else begin
            run_min_reg     <= run_min_next;
            run_max_reg     <= run_max_next;
            frame_min_reg   <= frame_min_next;
            frame_range_reg <= frame_range_next;
        end
    end

    // distance above the frame minimum, only meaningful for positive depth
    assign diff = signed'({1'b0, dval}) - signed'({1'b0, frame_min_reg});

    always_comb begin
        q_ctl.last = s_last;
        if (!depth_pos || (frame_range_reg == '0)) begin
            q_ctl.kind = dtj_pkg::KIND_ZERO;
        end else if (diff[DEPTH_BITS-1] || (diff == '0)) begin
            q_ctl.kind = dtj_pkg::KIND_LOW;
        end else if (diff[VB-1:0] >= frame_range_reg) begin
            q_ctl.kind = dtj_pkg::KIND_HIGH;
        end else begin
            q_ctl.kind = dtj_pkg::KIND_DIV;
        end
    end

    assign q_push  = accept && (s_func == dtj_pkg::FUNC_COLOUR);
    assign q_diff  = diff[VB-1:0];
    assign q_range = frame_range_reg;

endmodule

@@ hdl/dtj_queue.sv @@
// small first-in first-out queue between front and back end
module dtj_queue #(
    parameter int WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = dtj_pkg::QUEUE_AW;

    logic [WIDTH-1:0] mem_reg [dtj_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == (AW+1)'(dtj_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/dtj_back.sv @@
// back end: bit-serial ratio divider, tent colour ramp and output register
module dtj_back #(
    parameter int DEPTH_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_empty,
    input  dtj_pkg::item_ctl_t    q_ctl,
    input  logic [DEPTH_BITS-2:0] q_diff,
    input  logic [DEPTH_BITS-2:0] q_range,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_rgba,
    output logic                  m_last
);

    localparam int VB    = DEPTH_BITS - 1;
    localparam int F     = FRAC_BITS;
    localparam int VW    = F + 3;
    localparam int CNT_W = $clog2(F);

    localparam logic signed [VW-1:0] Q1   = VW'(1 << (F - 2));
    localparam logic signed [VW-1:0] Q3   = VW'(3 << (F - 2));
    localparam logic signed [VW-1:0] HALF = VW'(1 << (F - 1));
    localparam logic [F:0]           ONE  = (F+1)'(1 << F);

    dtj_pkg::back_state_t state_reg, state_next;

    logic [F:0]       u_reg, u_next;
    logic [VB-1:0]    rem_reg, rem_next;
    logic [VB-1:0]    den_reg, den_next;
    logic [F-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             zero_reg, zero_next;
    logic             last_reg, last_next;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_rgba_reg, m_rgba_next;
    logic             m_last_reg, m_last_next;

    logic             out_free;
    logic             div_done;
    logic             emit;
    logic [VB:0]      shifted;
    logic [VB:0]      trial;
    logic signed [VW-1:0] u_ext;
    logic [7:0]       red, green, blue;

    // floor(255 * tent(v)) with v in signed fixed point
    function automatic logic [7:0] tent(input logic signed [VW-1:0] v);
        logic signed [VW-1:0] b;
        logic [F+8:0]         prod;
        if (v <= -Q3) begin
            b = '0;
        end else if (v <= -Q1) begin
            b = (v + Q3) <<< 1;
        end else if (v <= Q1) begin
            b = signed'(VW'(ONE));
        end else if (v <= Q3) begin
            b = (Q3 - v) <<< 1;
        end else begin
            b = '0;
        end
        prod = ({8'd0, b[F:0]} << 8) - {8'd0, b[F:0]};
        return prod[F+7:F];
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign div_done = (cnt_reg == CNT_W'(F - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtj_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_ctl.kind == dtj_pkg::KIND_DIV) ? dtj_pkg::BK_DIV
                                                                   : dtj_pkg::BK_EMIT;
                end
            end
            dtj_pkg::BK_DIV: begin
                if (div_done) begin
                    state_next = dtj_pkg::BK_EMIT;
                end
            end
            dtj_pkg::BK_EMIT: begin
                if (out_free) begin
                    state_next = dtj_pkg::BK_IDLE;
                end
            end
            default: state_next = dtj_pkg::BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop = 1'b0;
        emit  = 1'b0;
        unique case (state_reg)
            dtj_pkg::BK_IDLE: q_pop = !q_empty;
            dtj_pkg::BK_DIV:  q_pop = 1'b0;
            dtj_pkg::BK_EMIT: emit  = out_free;
            default: begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    // one quotient bit per cycle, remainder always below the range
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};

    assign u_ext = signed'({2'b00, u_reg});
    assign red   = tent(u_ext - HALF);
    assign green = tent(u_ext);
    assign blue  = tent(u_ext + HALF);

    always_comb begin
        u_next       = u_reg;
        rem_next     = rem_reg;
        den_next     = den_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        zero_next    = zero_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;
        m_rgba_next  = m_rgba_reg;
        m_last_next  = m_last_reg;

        if (q_pop) begin
            last_next = q_ctl.last;
            zero_next = (q_ctl.kind == dtj_pkg::KIND_ZERO);
            u_next    = (q_ctl.kind == dtj_pkg::KIND_HIGH) ? ONE : '0;
            rem_next  = q_diff;
            den_next  = q_range;
            quo_next  = '0;
            cnt_next  = '0;
        end

        if (state_reg == dtj_pkg::BK_DIV) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = trial[VB-1:0];
                quo_next = {quo_reg[F-2:0], 1'b1};
            end else begin
                rem_next = shifted[VB-1:0];
                quo_next = {quo_reg[F-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (div_done) begin
                u_next = {1'b0, quo_next};
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (emit) begin
            m_valid_next = 1'b1;
            m_last_next  = last_reg;
            m_rgba_next  = zero_reg ? 32'd0 : {dtj_pkg::ALPHA_OPAQUE, blue, green, red};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dtj_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_reg      <= u_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        zero_reg   <= zero_next;
        last_reg   <= last_next;
        m_rgba_reg <= m_rgba_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_rgba  = m_rgba_reg;
    assign m_last  = m_last_reg;

endmodule

@@ hdl/depth_to_jet_colour.sv @@
// depth_to_jet_colour: two-pass auto-ranging jet colour map for a depth stream
//
// s_axis carries one depth sample per transaction; tuser selects the pass
// (0 = scan, 1 = colour) and tlast marks the final pixel of the frame.
// a scan transaction updates the running minimum and maximum of positive
// depths; the scan transaction with tlast latches the frame minimum and range.
// a colour transaction produces one RGBA pixel on m_axis, tlast copied through.
// scan transactions produce nothing.
// a colour transaction goes through a four-entry queue into the back end;
// depths that need the ratio (d - min) / range pass through the
// one-bit-per-cycle divider before the output register; clamped or
// invalid pixels skip the divider.
// the back end handles one colour item at a time, so it takes no new
// item from the queue before the last one has gone to the output register.
// when the receiver stalls the output register holds its pixel, the back end
// waits, the queue fills and s_axis_tready drops once it is full.
// reset (aresetn low, synchronous) empties the queue and output register,
// sets frame minimum and range to zero and restarts the accumulators.
`include "depth_to_jet_colour_macros.svh"

module depth_to_jet_colour #(
    parameter int DEPTH_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slave side: depth samples
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((DEPTH_BITS+7)/8)*8-1:0]     s_axis_tdata,  // depth, zero padded
    input  logic                                s_axis_tuser,  // func
    input  logic                                s_axis_tlast,  // last
    // master side: colour pixels
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // red, green, blue, alpha
    output logic                                m_axis_tlast   // frame_end
);

    localparam int VB = DEPTH_BITS - 1;
    localparam int QW = $bits(dtj_pkg::item_ctl_t) + 2 * VB;

    // front to queue
    logic                       f_push;
    dtj_pkg::item_ctl_t         f_ctl;
    logic [VB-1:0]              f_diff;
    logic [VB-1:0]              f_range;
    logic                       q_full;

    // queue to back
    logic [QW-1:0]              q_data;
    logic                       q_empty;
    logic                       q_pop;
    dtj_pkg::item_ctl_t         b_ctl;
    logic [VB-1:0]              b_diff;
    logic [VB-1:0]              b_range;

    logic signed [DEPTH_BITS-1:0] s_depth;

    assign s_depth = signed'(s_axis_tdata[DEPTH_BITS-1:0]);

    dtj_front #(
        .DEPTH_BITS(DEPTH_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_func  (s_axis_tuser),
        .s_depth (s_depth),
        .s_last  (s_axis_tlast),
        .q_full  (q_full),
        .q_push  (f_push),
        .q_ctl   (f_ctl),
        .q_diff  (f_diff),
        .q_range (f_range)
    );

    dtj_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_push),
        .push_data ({f_ctl, f_diff, f_range}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    assign {b_ctl, b_diff, b_range} = q_data;

    dtj_back #(
        .DEPTH_BITS(DEPTH_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_ctl   (b_ctl),
        .q_diff  (b_diff),
        .q_range (b_range),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_rgba  (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

    // scan transactions never reach the queue
    `DTJ_ASSERT_NOW(a_scan_no_push, aclk, aresetn, s_axis_tvalid && s_axis_tready && (s_axis_tuser == dtj_pkg::FUNC_SCAN), !f_push, "scan item entered the queue")
    // the front never pushes into a full queue
    `DTJ_ASSERT_NOW(a_no_overflow, aclk, aresetn, f_push, !q_full, "push into full queue")
    // the back end takes one item and works on it before taking another
    `DTJ_ASSERT_NEXT(a_single_pop, aclk, aresetn, q_pop, !q_pop, "back end popped twice in a row")
    // a transparent pixel is all black
    `DTJ_ASSERT_NOW(a_zero_pixel, aclk, aresetn, m_axis_tvalid && (m_axis_tdata[31:24] != dtj_pkg::ALPHA_OPAQUE), m_axis_tdata == 32'd0, "invalid pixel carries colour")

endmodule
